FILE: rtl/core/zyzht_pkg.sv
// Shared constants, types and fixed-point helpers for the ZYZ Euler transform core.
// No dependencies.
package zyzht_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int QTR_BITS       = ANGLE_BITS - 2;
    localparam int IDX_W          = QTR_BITS + 1;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int TRANS_W        = 32;

    // quarter-wave evaluator internals (x in Q1.30)
    localparam int X_W      = 31;
    localparam int X2_W     = 32;
    localparam int T_W      = 31;
    localparam int XP_W     = IDX_W + X_W;
    localparam int P_W      = X2_W + T_W;
    localparam int A_W      = 32;
    localparam int R_W      = 30;
    localparam int QP_W     = A_W + R_W;
    localparam int QV_W     = QP_W - 32;
    localparam int FP_W     = X_W + T_W;
    localparam int S_W      = FP_W - 29;
    localparam int ENTRY_SHIFT = 30 - COEF_FRAC_BITS;

    localparam logic [X_W-1:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [T_W-1:0] T_ONE      = 31'd1073741824;

    localparam int HORNER_STEPS = 6;
    localparam logic [7:0] HORNER_K [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [R_W-1:0] HORNER_R [HORNER_STEPS] = '{
        30'(64'd4294967296 / 64'd156), 30'(64'd4294967296 / 64'd110),
        30'(64'd4294967296 / 64'd72),  30'(64'd4294967296 / 64'd42),
        30'(64'd4294967296 / 64'd20),  30'(64'd4294967296 / 64'd6)};

    // angle context register, input stage through the final scale
    localparam int SIN_LAT  = 3 * HORNER_STEPS + 4;
    localparam int CTX_N    = SIN_LAT - 1;
    localparam int PIPE_LAT = SIN_LAT + 4;

    localparam int NUM_SIN  = 6;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int SUM_W    = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] COEF_ONE = SUM_W'(1) << COEF_FRAC_BITS;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [X2_W-1:0] x2;
        logic            neg;
    } sin_ctx_t;

    // divide by 2^F, rounding half up
    function automatic logic signed [SUM_W-1:0] coef_rnd(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] w;
        w = v + (COEF_ONE >>> 1);
        return w >>> COEF_FRAC_BITS;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > COEF_ONE)
            c = COEF_ONE;
        if (v < -COEF_ONE)
            c = -COEF_ONE;
        return COEF_W'(c);
    endfunction

endpackage

FILE: rtl/core/zyzht_sin_pipe.sv
// Pipelined binary-angle sine: quarter-wave fold, then Horner series in Q2.30.
// Depends on zyzht_pkg. Takes one angle per cycle.
module zyzht_sin_pipe
    import zyzht_pkg::*;
(
    input  logic                     clk,
    input  logic [ANGLE_BITS-1:0]    angle,
    output logic signed [COEF_W-1:0] value
);

    sin_ctx_t          ctx_reg  [CTX_N];
    sin_ctx_t          ctx_next [CTX_N];
    logic [P_W-1:0]    p_reg    [HORNER_STEPS];
    logic [P_W-1:0]    p_next   [HORNER_STEPS];
    logic [A_W-1:0]    a_reg    [HORNER_STEPS];
    logic [A_W-1:0]    a_next   [HORNER_STEPS];
    logic [QP_W-1:0]   qp_reg   [HORNER_STEPS];
    logic [QP_W-1:0]   qp_next  [HORNER_STEPS];
    logic [T_W-1:0]    t_reg    [HORNER_STEPS];
    logic [T_W-1:0]    t_next   [HORNER_STEPS];
    logic [FP_W-1:0]   fp_reg, fp_next;
    logic signed [COEF_W-1:0] value_reg, value_next;

    logic [1:0]        quad;
    logic [IDX_W-1:0]  idx;
    logic [XP_W-1:0]   xprod;
    logic [63:0]       xsq;
    logic [QV_W-1:0]   qv   [HORNER_STEPS];
    logic [A_W:0]      rem  [HORNER_STEPS];
    logic [T_W-1:0]    mval [HORNER_STEPS];
    logic [S_W-1:0]    s_val;
    logic [S_W-1:0]    entry;

    always_comb
    begin
        quad  = angle[ANGLE_BITS-1 -: 2];
        idx   = quad[0] ? (IDX_W'(1) << QTR_BITS) - IDX_W'(angle[QTR_BITS-1:0])
                        : IDX_W'(angle[QTR_BITS-1:0]);
        xprod = XP_W'(idx) * XP_W'(HALFPI_Q30);
        ctx_next[0].x   = X_W'((xprod + (XP_W'(1) << (QTR_BITS - 1))) >> QTR_BITS);
        ctx_next[0].x2  = '0;
        ctx_next[0].neg = quad[1];

        xsq = 64'(ctx_reg[0].x) * 64'(ctx_reg[0].x);
        ctx_next[1]    = ctx_reg[0];
        ctx_next[1].x2 = X2_W'((xsq + (64'(1) << 29)) >> 30);
        for (int j = 2; j < CTX_N; j++)
            ctx_next[j] = ctx_reg[j-1];

        for (int i = 0; i < HORNER_STEPS; i++)
        begin
            p_next[i]  = P_W'(ctx_reg[1 + 3*i].x2) * P_W'((i == 0) ? T_ONE : t_reg[(i == 0) ? 0 : i-1]);
            a_next[i]  = A_W'((64'(p_reg[i]) + (64'(HORNER_K[i]) << 29)) >> 30);
            qp_next[i] = QP_W'(a_next[i]) * QP_W'(HORNER_R[i]);
            // reciprocal estimate is low by at most one
            qv[i]      = QV_W'(qp_reg[i] >> 32);
            rem[i]     = (A_W+1)'(a_reg[i]) - (A_W+1)'(qv[i]) * (A_W+1)'(HORNER_K[i]);
            mval[i]    = T_W'(qv[i]) + T_W'(rem[i] >= (A_W+1)'(HORNER_K[i]));
            t_next[i]  = T_ONE - mval[i];
        end

        fp_next = FP_W'(ctx_reg[CTX_N-2].x) * FP_W'(t_reg[HORNER_STEPS-1]);
        s_val   = S_W'((fp_reg + (FP_W'(1) << 29)) >> 30);
        if (s_val > S_W'(T_ONE))
            s_val = S_W'(T_ONE);
        entry = (s_val + (S_W'(1) << (ENTRY_SHIFT - 1))) >> ENTRY_SHIFT;
        value_next = ctx_reg[CTX_N-1].neg ? -COEF_W'(entry) : COEF_W'(entry);
    end

    always_ff @(posedge clk)
    begin
        ctx_reg   <= ctx_next;
        p_reg     <= p_next;
        a_reg     <= a_next;
        qp_reg    <= qp_next;
        t_reg     <= t_next;
        fp_reg    <= fp_next;
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/core/zyz_euler_homogeneous_transform_core.sv
// ZYZ Euler angles to homogeneous transform, top level.
// Depends on zyzht_pkg and zyzht_sin_pipe.
//
// Usage:
//   Drive angle_first/second/third (binary angle, 65536 per turn) and
//   trans_x/y/z (Q16.16) with start high; the item transfers at any edge
//   where start is high and busy is low. busy stays low: the pipeline
//   takes a new pose every cycle.
//   Results r11..r33 (Q1.14, R = Rz(a)*Ry(b)*Rz(c)) and out_x/y/z appear
//   with done high for exactly one cycle.
//   Latency is set by the six parallel sine pipelines (22 stages: fold,
//   square, three stages per Horner term, final scale) plus input
//   register and three matrix stages (products, second products, sum and
//   saturate).
//   Throughput: one pose per cycle.
//   Reset clears the valid chain only; nothing is in flight afterwards.
//   The receiver cannot stall; results must be taken on the done cycle.
module zyz_euler_homogeneous_transform_core
    import zyzht_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ANGLE_BITS-1:0]     angle_first,
    input  logic [ANGLE_BITS-1:0]     angle_second,
    input  logic [ANGLE_BITS-1:0]     angle_third,
    input  logic signed [TRANS_W-1:0] trans_x,
    input  logic signed [TRANS_W-1:0] trans_y,
    input  logic signed [TRANS_W-1:0] trans_z,
    output logic                      done,
    output logic signed [COEF_W-1:0]  r11,
    output logic signed [COEF_W-1:0]  r12,
    output logic signed [COEF_W-1:0]  r13,
    output logic signed [COEF_W-1:0]  r21,
    output logic signed [COEF_W-1:0]  r22,
    output logic signed [COEF_W-1:0]  r23,
    output logic signed [COEF_W-1:0]  r31,
    output logic signed [COEF_W-1:0]  r32,
    output logic signed [COEF_W-1:0]  r33,
    output logic signed [TRANS_W-1:0] out_x,
    output logic signed [TRANS_W-1:0] out_y,
    output logic signed [TRANS_W-1:0] out_z
);

    localparam int SA = 0, CA = 1, SB = 2, CB = 3, SC = 4, CC = 5;

    logic [PIPE_LAT-1:0]         vld_reg, vld_next;
    logic [ANGLE_BITS-1:0]       ang_reg [3];
    logic [3*TRANS_W-1:0]        tr_reg  [PIPE_LAT];
    logic [ANGLE_BITS-1:0]       sin_in  [NUM_SIN];
    logic signed [COEF_W-1:0]    sv      [NUM_SIN];

    // stage 1: first products
    logic signed [PROD_W-1:0]    cacb_reg, sacb_reg, casb_reg, sasb_reg, sbcc_reg, sbsc_reg;
    logic signed [PROD_W-1:0]    sasc_reg, sacc_reg, casc_reg, cacc_reg;
    logic signed [COEF_W-1:0]    cc1_reg, sc1_reg, cb1_reg;
    // stage 2: second products
    logic signed [PROD_W-1:0]    uc_reg, us_reg, vc_reg, vs_reg;
    logic signed [PROD_W-1:0]    casb2_reg, sasb2_reg, sbcc2_reg, sbsc2_reg;
    logic signed [PROD_W-1:0]    sasc2_reg, sacc2_reg, casc2_reg, cacc2_reg;
    logic signed [COEF_W-1:0]    cb2_reg;
    logic signed [COEF_W-1:0]    u_val, v_val;
    // stage 3: outputs
    logic signed [COEF_W-1:0]    r11_reg, r12_reg, r13_reg, r21_reg, r22_reg, r23_reg;
    logic signed [COEF_W-1:0]    r31_reg, r32_reg, r33_reg;

    logic xfer;

    assign busy     = 1'b0;
    assign xfer     = start & ~busy;
    assign vld_next = {vld_reg[PIPE_LAT-2:0], xfer};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= angle_first;
        ang_reg[1] <= angle_second;
        ang_reg[2] <= angle_third;
        tr_reg[0]  <= {trans_x, trans_y, trans_z};
        for (int j = 1; j < PIPE_LAT; j++)
            tr_reg[j] <= tr_reg[j-1];
    end

    // cosine is the sine a quarter turn ahead
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sin_in[2*k]     = ang_reg[k];
            sin_in[2*k + 1] = ang_reg[k] + (ANGLE_BITS'(1) << QTR_BITS);
        end
    end

    for (genvar g = 0; g < NUM_SIN; g++)
    begin : g_sin
        zyzht_sin_pipe u_sin (
            .clk   (clk),
            .angle (sin_in[g]),
            .value (sv[g])
        );
    end

    always_ff @(posedge clk)
    begin
        cacb_reg <= PROD_W'(sv[CA]) * PROD_W'(sv[CB]);
        sacb_reg <= PROD_W'(sv[SA]) * PROD_W'(sv[CB]);
        casb_reg <= PROD_W'(sv[CA]) * PROD_W'(sv[SB]);
        sasb_reg <= PROD_W'(sv[SA]) * PROD_W'(sv[SB]);
        sbcc_reg <= PROD_W'(sv[SB]) * PROD_W'(sv[CC]);
        sbsc_reg <= PROD_W'(sv[SB]) * PROD_W'(sv[SC]);
        sasc_reg <= PROD_W'(sv[SA]) * PROD_W'(sv[SC]);
        sacc_reg <= PROD_W'(sv[SA]) * PROD_W'(sv[CC]);
        casc_reg <= PROD_W'(sv[CA]) * PROD_W'(sv[SC]);
        cacc_reg <= PROD_W'(sv[CA]) * PROD_W'(sv[CC]);
        cc1_reg  <= sv[CC];
        sc1_reg  <= sv[SC];
        cb1_reg  <= sv[CB];
    end

    assign u_val = COEF_W'(coef_rnd(SUM_W'(cacb_reg)));
    assign v_val = COEF_W'(coef_rnd(SUM_W'(sacb_reg)));

    always_ff @(posedge clk)
    begin
        uc_reg    <= PROD_W'(u_val) * PROD_W'(cc1_reg);
        us_reg    <= PROD_W'(u_val) * PROD_W'(sc1_reg);
        vc_reg    <= PROD_W'(v_val) * PROD_W'(cc1_reg);
        vs_reg    <= PROD_W'(v_val) * PROD_W'(sc1_reg);
        casb2_reg <= casb_reg;
        sasb2_reg <= sasb_reg;
        sbcc2_reg <= sbcc_reg;
        sbsc2_reg <= sbsc_reg;
        sasc2_reg <= sasc_reg;
        sacc2_reg <= sacc_reg;
        casc2_reg <= casc_reg;
        cacc2_reg <= cacc_reg;
        cb2_reg   <= cb1_reg;
    end

    always_ff @(posedge clk)
    begin
        r11_reg <= coef_sat(coef_rnd(SUM_W'(uc_reg) - SUM_W'(sasc2_reg)));
        r12_reg <= coef_sat(coef_rnd(-SUM_W'(us_reg) - SUM_W'(sacc2_reg)));
        r13_reg <= coef_sat(coef_rnd(SUM_W'(casb2_reg)));
        r21_reg <= coef_sat(coef_rnd(SUM_W'(vc_reg) + SUM_W'(casc2_reg)));
        r22_reg <= coef_sat(coef_rnd(-SUM_W'(vs_reg) + SUM_W'(cacc2_reg)));
        r23_reg <= coef_sat(coef_rnd(SUM_W'(sasb2_reg)));
        r31_reg <= coef_sat(coef_rnd(-SUM_W'(sbcc2_reg)));
        r32_reg <= coef_sat(coef_rnd(SUM_W'(sbsc2_reg)));
        r33_reg <= cb2_reg;
    end

    assign done  = vld_reg[PIPE_LAT-1];
    assign r11   = r11_reg;
    assign r12   = r12_reg;
    assign r13   = r13_reg;
    assign r21   = r21_reg;
    assign r22   = r22_reg;
    assign r23   = r23_reg;
    assign r31   = r31_reg;
    assign r32   = r32_reg;
    assign r33   = r33_reg;
    assign out_x = tr_reg[PIPE_LAT-1][3*TRANS_W-1 -: TRANS_W];
    assign out_y = tr_reg[PIPE_LAT-1][2*TRANS_W-1 -: TRANS_W];
    assign out_z = tr_reg[PIPE_LAT-1][TRANS_W-1:0];

    // every result traces back to one transfer a fixed latency earlier
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(xfer, PIPE_LAT))
        else $error("result without matching input transfer");

    a_r33_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r33 <= COEF_W'(COEF_ONE) && r33 >= -COEF_W'(COEF_ONE)))
        else $error("r33 outside unit range");

    a_r11_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r11 <= COEF_W'(COEF_ONE) && r11 >= -COEF_W'(COEF_ONE)))
        else $error("r11 outside unit range");

endmodule

FILE: test/tb_zyz_euler_homogeneous_transform_core.sv
// Self-checking testbench for zyz_euler_homogeneous_transform_core.
// Depends on zyzht_pkg and the core RTL; a local fixed-point model predicts each pose.
module tb_zyz_euler_homogeneous_transform_core;
    import zyzht_pkg::*;

    localparam int QTR = 1 << QTR_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_POSES = 1030;
    localparam int QUIET_TAIL = 100;

    typedef struct {
        logic [ANGLE_BITS-1:0]     a, b, c;
        logic signed [TRANS_W-1:0] tx, ty, tz;
    } pose_t;

    typedef struct {
        logic signed [COEF_W-1:0]  rot [9];
        logic signed [TRANS_W-1:0] tr [3];
    } xform_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done;
    logic [ANGLE_BITS-1:0] angle_first = '0, angle_second = '0, angle_third = '0;
    logic signed [TRANS_W-1:0] trans_x = '0, trans_y = '0, trans_z = '0;
    logic signed [COEF_W-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
    logic signed [TRANS_W-1:0] out_x, out_y, out_z;

    longint sine_tbl [QTR+1];
    pose_t  pending_poses [$];
    xform_t expected_xforms [$];
    int     errors = 0;
    int     cycles = 0;
    int     idle_left = 0;

    zyz_euler_homogeneous_transform_core dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint quarter_sine(longint unsigned p);
        longint unsigned x, x2, t, d, m, s;
        longint unsigned ks [6] = '{156, 110, 72, 42, 20, 6};
        x = (p * 64'd1686629713 + (QTR >> 1)) >> QTR_BITS;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
        begin
            d = ks[i] << 30;
            m = (x2 * t + (d >> 1)) / d;
            t = (64'd1 << 30) - m;
        end
        s = (x * t + (64'd1 << 29)) >> 30;
        if (s > (64'd1 << 30))
            s = 64'd1 << 30;
        s = (s + (64'd1 << (ENTRY_SHIFT - 1))) >> ENTRY_SHIFT;
        return longint'(s);
    endfunction

    function automatic longint sin_ang(logic [ANGLE_BITS-1:0] ang);
        logic [QTR_BITS-1:0] p;
        longint v;
        p = ang[QTR_BITS-1:0];
        v = ang[ANGLE_BITS-2] ? sine_tbl[QTR - p] : sine_tbl[p];
        return ang[ANGLE_BITS-1] ? -v : v;
    endfunction

    function automatic longint cos_ang(logic [ANGLE_BITS-1:0] ang);
        logic [ANGLE_BITS-1:0] sh;
        sh = ang + ANGLE_BITS'(QTR);
        return sin_ang(sh);
    endfunction

    // arithmetic shift floors, which matches round half up
    function automatic longint coef_round(longint v);
        return (v + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_clip(longint v);
        longint r;
        r = coef_round(v);
        if (r > (64'sd1 <<< COEF_FRAC_BITS))
            r = 64'sd1 <<< COEF_FRAC_BITS;
        if (r < -(64'sd1 <<< COEF_FRAC_BITS))
            r = -(64'sd1 <<< COEF_FRAC_BITS);
        return COEF_W'(r);
    endfunction

    function automatic xform_t zyz_transform(pose_t ps);
        xform_t e;
        longint sa, ca, sb, cb, sc, cc, u, v;
        sa = sin_ang(ps.a);
        ca = cos_ang(ps.a);
        sb = sin_ang(ps.b);
        cb = cos_ang(ps.b);
        sc = sin_ang(ps.c);
        cc = cos_ang(ps.c);
        u = coef_round(ca * cb);
        v = coef_round(sa * cb);
        e.rot[0] = coef_clip(u * cc - sa * sc);
        e.rot[1] = coef_clip(-(u * sc) - sa * cc);
        e.rot[2] = coef_clip(ca * sb);
        e.rot[3] = coef_clip(v * cc + ca * sc);
        e.rot[4] = coef_clip(-(v * sc) + ca * cc);
        e.rot[5] = coef_clip(sa * sb);
        e.rot[6] = coef_clip(-(sb * cc));
        e.rot[7] = coef_clip(sb * sc);
        e.rot[8] = COEF_W'(cb);
        e.tr[0] = ps.tx;
        e.tr[1] = ps.ty;
        e.tr[2] = ps.tz;
        return e;
    endfunction

    function automatic pose_t make_pose(int a, int b, int c, int tx, int ty, int tz);
        pose_t ps;
        ps.a = ANGLE_BITS'(a);
        ps.b = ANGLE_BITS'(b);
        ps.c = ANGLE_BITS'(c);
        ps.tx = TRANS_W'(tx);
        ps.ty = TRANS_W'(ty);
        ps.tz = TRANS_W'(tz);
        return ps;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] rand_angle();
        // half the time land near a quadrant boundary
        if ($urandom_range(0, 1))
            return ANGLE_BITS'($urandom());
        return ANGLE_BITS'($urandom_range(0, 3) * QTR + $urandom_range(0, 6) - 3);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // driver: a transfer happens on an edge with start high and busy low
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_xforms.push_back(zyz_transform(pending_poses.pop_front()));
                if (pending_poses.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 3);
            end
            if (start && busy)
                start <= 1'b1;
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_poses.size() > 0)
            begin
                start <= 1'b1;
                angle_first <= pending_poses[0].a;
                angle_second <= pending_poses[0].b;
                angle_third <= pending_poses[0].c;
                trans_x <= pending_poses[0].tx;
                trans_y <= pending_poses[0].ty;
                trans_z <= pending_poses[0].tz;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        xform_t e;
        logic signed [COEF_W-1:0] got_rot [9];
        logic signed [TRANS_W-1:0] got_tr [3];
        if (rst_n && done)
        begin
            got_rot = '{r11, r12, r13, r21, r22, r23, r31, r32, r33};
            got_tr = '{out_x, out_y, out_z};
            if (expected_xforms.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer, expected none, got r11=%0d",
                         $time, r11);
            end
            else
            begin
                e = expected_xforms.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got_rot[i] !== e.rot[i])
                    begin
                        errors++;
                        $display("%0t: r%0d%0d expected %0d got %0d", $time,
                                 i / 3 + 1, i % 3 + 1, e.rot[i], got_rot[i]);
                    end
                for (int i = 0; i < 3; i++)
                    if (got_tr[i] !== e.tr[i])
                    begin
                        errors++;
                        $display("%0t: translation %0d expected %0d got %0d", $time,
                                 i, e.tr[i], got_tr[i]);
                    end
            end
        end
    end

    initial
    begin
        for (int p = 0; p <= QTR; p++)
            sine_tbl[p] = quarter_sine(p);
        // directed: axes, quadrant edges, all-ones, gimbal lock, translation extremes
        pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 0));
        pending_poses.push_back(make_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, -1, -1, -1));
        pending_poses.push_back(make_pose(16'h4000, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1));
        pending_poses.push_back(make_pose(0, 16'h4000, 0, 32'h80000000, 32'h7FFFFFFF, 0));
        pending_poses.push_back(make_pose(0, 0, 16'h4000, 32'h00010000, -32'h00010000, 5));
        pending_poses.push_back(make_pose(16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
        pending_poses.push_back(make_pose(16'hC000, 16'hC000, 16'hC000, 0, 0, 0));
        pending_poses.push_back(make_pose(16'h2000, 16'h2000, 16'h2000, 7, 8, 9));
        pending_poses.push_back(make_pose(16'h3FFF, 16'h4001, 16'h7FFF, 0, 0, 0));
        pending_poses.push_back(make_pose(16'h8001, 16'hBFFF, 16'hC001, 0, 0, 0));
        pending_poses.push_back(make_pose(16'h1234, 0, 16'hEDCC, 0, 0, 0));
        pending_poses.push_back(make_pose(16'h1234, 16'h8000, 16'h5678, 0, 0, 0));
        pending_poses.push_back(make_pose(16'h0001, 16'h0001, 16'h0001, 1, 1, 1));
        pending_poses.push_back(make_pose(16'hAAAA, 16'h5555, 16'hAAAA,
                                          32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
        pending_poses.push_back(make_pose(16'h5555, 16'hAAAA, 16'h5555,
                                          32'h55555555, 32'hAAAAAAAA, 32'h55555555));
        for (int n = 0; n < RANDOM_POSES; n++)
            pending_poses.push_back(make_pose(int'(rand_angle()), int'(rand_angle()),
                                              int'(rand_angle()),
                                              $urandom(), $urandom(), $urandom()));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_poses.size() == 0 && expected_xforms.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
